>>> rtl/core/region_protected_bus_memory_macros.svh
// Assertion macros shared by the checker of the protected bus memory.
// Relies on a clock named clk and an active-low reset named rst_n in scope.
`ifndef REGION_PROTECTED_BUS_MEMORY_MACROS_SVH
`define REGION_PROTECTED_BUS_MEMORY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPBM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rpbm_pkg.sv
// Package of the region protected bus memory: widths, codes and shared types.
// Used by the region check, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package rpbm_pkg;

    localparam int ADDR_BITS_DEFAULT = 16;
    localparam int REG_W             = 17;
    localparam int NUM_REGS          = 8;
    localparam int REG_IDX_W         = 3;
    localparam int ADDR_IN_W         = 16;
    localparam int WDATA_W           = 32;
    localparam int BYTE_LANES        = 4;

    // Positions of the input fields inside s_axis_tdata.
    localparam int SIZE_LSB   = 0;
    localparam int ADDR_LSB   = 2;
    localparam int WDATA_LSB  = ADDR_LSB + ADDR_IN_W;
    localparam int IN_TDATA_W = 56;

    // Access kind.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Access size codes; the unused code behaves as a four-byte access.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_VECTOR_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_VECTOR_END   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CODE_START   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CODE_END     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DATA_START   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DATA_END     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STACK_START  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_STACK_END    = 3'd7;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_UNALIGNED = 2'd1,
        FAULT_REGION    = 2'd2
    } fault_kind_t;

    typedef struct packed {
        logic [REG_W-1:0] start_addr;
        logic [REG_W-1:0] end_addr;
    } region_t;

    typedef struct packed {
        region_t vector_r;
        region_t code_r;
        region_t data_r;
        region_t stack_r;
    } regions_t;

endpackage

>>> rtl/core/rpbm_bank.sv
// One byte lane of the protected bus memory: a single-port byte array with
// a registered read. Depends on nothing but its row width parameter.
`timescale 1ns / 1ps

module rpbm_bank #(
    parameter int ROW_BITS = 14
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic                wr_en,
    input  logic [ROW_BITS-1:0] row,
    input  logic [7:0]          wr_byte,
    output logic [7:0]          rd_byte
);

    logic [7:0] bytes_mem [(1 << ROW_BITS)];
    logic [7:0] rd_byte_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bytes_mem[row] <= wr_byte;
        end
        if (rd_en)
        begin
            rd_byte_reg <= bytes_mem[row];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

>>> rtl/core/rpbm_region_check.sv
// Alignment and region permission check for one access.
// Depends on rpbm_pkg for the region types and fault codes.
`timescale 1ns / 1ps

module rpbm_region_check #(
    parameter int ADDR_BITS = rpbm_pkg::ADDR_BITS_DEFAULT
) (
    input  logic [ADDR_BITS-1:0]  addr,
    input  logic [1:0]            size,
    input  logic                  is_write,
    input  rpbm_pkg::regions_t    regions,
    output rpbm_pkg::fault_kind_t kind
);

    // Wide enough for the largest address plus four and every region bound.
    localparam int CMP_W = ((ADDR_BITS > rpbm_pkg::REG_W) ? ADDR_BITS : rpbm_pkg::REG_W) + 1;

    logic [2:0]       span_len;
    logic [CMP_W-1:0] first;
    logic [CMP_W-1:0] after;
    logic             in_vector;
    logic             in_code;
    logic             in_data;
    logic             in_stack;
    logic             permitted;

    function automatic logic span_in(input logic [CMP_W-1:0] lo,
                                     input logic [CMP_W-1:0] hi,
                                     input rpbm_pkg::region_t r);
        return (lo >= CMP_W'(r.start_addr)) && (hi <= CMP_W'(r.end_addr));
    endfunction

    always_comb
    begin
        case (size)
            rpbm_pkg::SIZE_BYTE: span_len = 3'd1;
            rpbm_pkg::SIZE_HALF: span_len = 3'd2;
            default:             span_len = 3'd4;
        endcase
    end

    assign first     = CMP_W'(addr);
    assign after     = first + CMP_W'(span_len);
    assign in_vector = span_in(first, after, regions.vector_r);
    assign in_code   = span_in(first, after, regions.code_r);
    assign in_data   = span_in(first, after, regions.data_r);
    assign in_stack  = span_in(first, after, regions.stack_r);
    assign permitted = in_vector || (!is_write && in_code) || in_data || in_stack;

    // Alignment is checked first, so an odd multi-byte access reports unaligned.
    always_comb
    begin
        if ((size != rpbm_pkg::SIZE_BYTE) && addr[0])
        begin
            kind = rpbm_pkg::FAULT_UNALIGNED;
        end
        else if (!permitted)
        begin
            kind = rpbm_pkg::FAULT_REGION;
        end
        else
        begin
            kind = rpbm_pkg::FAULT_NONE;
        end
    end

endmodule

>>> rtl/core/region_protected_bus_memory.sv
// Top level of the region protected bus memory.
// Depends on rpbm_pkg, rpbm_region_check and rpbm_bank.
`timescale 1ns / 1ps

// Byte-addressed, big-endian bus memory with region protection. Each item on
// the slave stream is a read or a write of one, two or four bytes; each item
// yields exactly one result item on the master stream, in order. The block
// takes one item per clock cycle while the master side does not stall. That
// rate is set by the storage: it is split into four byte lanes, each a
// single-port array with a registered read, and the four bytes of any access
// (even one that straddles a word boundary) fall into four different lanes,
// so every access touches each lane at most once. An access of two or four
// bytes at an odd address faults as unaligned; otherwise its whole span must
// lie in one permitted region, where region ends are exclusive and an empty
// region has start not below end. Reads may use the vector, code, data and
// stack regions; writes only vector, data and stack. A faulting item writes
// nothing and reads zero, and sets the sticky fault_seen flag, which only
// reset clears. Writes read back zero. Memory contents are undefined until
// written. Region registers reset to zero, so after reset every access
// faults. The user must write them through the cfg port only while the
// block is idle; the block itself does not enforce this.

module region_protected_bus_memory #(
    parameter int ADDR_BITS = rpbm_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [rpbm_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [rpbm_pkg::REG_W-1:0]          cfg_data,

    // Access items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // From bit 0: access_size[1:0], address[15:0], write_data[31:0], zero fill.
    input  logic [rpbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Bit 0: cmd (0 read, 1 write).
    input  logic                                s_axis_tuser,

    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0: read_data[31:0].
    output logic [31:0]                         m_axis_tdata,
    // From bit 0: fault_kind[1:0], fault_seen.
    output logic [2:0]                          m_axis_tuser
);

    localparam int ROW_BITS = ADDR_BITS - 2;

    // Region registers.
    logic [rpbm_pkg::REG_W-1:0] region_reg [rpbm_pkg::NUM_REGS];
    rpbm_pkg::regions_t         regions;

    // Stage 1: registered input item.
    logic                       s1_valid_reg;
    logic                       s1_write_reg;
    logic [1:0]                 s1_size_reg;
    logic [ADDR_BITS-1:0]       s1_addr_reg;
    logic [31:0]                s1_wdata_reg;

    // Stage 2: memory access done, lane bytes registered inside the banks.
    logic                       s2_valid_reg;
    logic [1:0]                 s2_lo_reg;
    logic [1:0]                 s2_last_reg;
    logic                       s2_zero_reg;
    rpbm_pkg::fault_kind_t      s2_kind_reg;
    logic                       s2_seen_reg;

    // Result register.
    logic                       out_valid_reg;
    logic [31:0]                out_data_reg;
    rpbm_pkg::fault_kind_t      out_kind_reg;
    logic                       out_seen_reg;

    logic                       sticky_reg;
    logic                       sticky_next;

    logic                       out_load;
    logic                       s2_load;
    logic                       s1_load;
    logic                       s1_fire;
    logic [ADDR_BITS-1:0]       in_addr;
    rpbm_pkg::fault_kind_t      s1_kind;
    logic                       s1_ok;
    logic [1:0]                 s1_last;
    logic [7:0]                 lane_rd   [rpbm_pkg::BYTE_LANES];
    logic [7:0]                 span_byte [rpbm_pkg::BYTE_LANES];
    logic [31:0]                rdata;

    // ------------------------------------------------------------------
    // Configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rpbm_pkg::NUM_REGS; i++)
            begin
                region_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            region_reg[cfg_index] <= cfg_data;
        end
    end

    assign regions.vector_r.start_addr = region_reg[rpbm_pkg::REG_VECTOR_START];
    assign regions.vector_r.end_addr   = region_reg[rpbm_pkg::REG_VECTOR_END];
    assign regions.code_r.start_addr   = region_reg[rpbm_pkg::REG_CODE_START];
    assign regions.code_r.end_addr     = region_reg[rpbm_pkg::REG_CODE_END];
    assign regions.data_r.start_addr   = region_reg[rpbm_pkg::REG_DATA_START];
    assign regions.data_r.end_addr     = region_reg[rpbm_pkg::REG_DATA_END];
    assign regions.stack_r.start_addr  = region_reg[rpbm_pkg::REG_STACK_START];
    assign regions.stack_r.end_addr    = region_reg[rpbm_pkg::REG_STACK_END];

    // ------------------------------------------------------------------
    // Pipeline flow. A stage loads when it is empty or its item moves on.
    // ------------------------------------------------------------------
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s2_load       = !s2_valid_reg || out_load;
    assign s1_load       = !s1_valid_reg || s2_load;
    assign s1_fire       = s1_valid_reg && s2_load;
    assign s_axis_tready = s1_load;

    // The address is taken modulo the store size, or zero-extended into it.
    generate
        if (ADDR_BITS > rpbm_pkg::ADDR_IN_W)
        begin : g_addr_ext
            assign in_addr = {{(ADDR_BITS - rpbm_pkg::ADDR_IN_W){1'b0}},
                              s_axis_tdata[rpbm_pkg::ADDR_LSB +: rpbm_pkg::ADDR_IN_W]};
        end
        else
        begin : g_addr_cut
            assign in_addr = s_axis_tdata[rpbm_pkg::ADDR_LSB +: ADDR_BITS];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sticky_reg    <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_fire)
            begin
                sticky_reg <= sticky_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_write_reg <= s_axis_tuser;
            s1_size_reg  <= s_axis_tdata[rpbm_pkg::SIZE_LSB +: 2];
            s1_addr_reg  <= in_addr;
            s1_wdata_reg <= s_axis_tdata[rpbm_pkg::WDATA_LSB +: rpbm_pkg::WDATA_W];
        end
        if (s2_load)
        begin
            s2_lo_reg   <= s1_addr_reg[1:0];
            s2_last_reg <= s1_last;
            s2_zero_reg <= !s1_ok || (s1_write_reg == rpbm_pkg::CMD_WRITE);
            s2_kind_reg <= s1_kind;
            s2_seen_reg <= sticky_next;
        end
        if (out_load)
        begin
            out_data_reg <= rdata;
            out_kind_reg <= s2_kind_reg;
            out_seen_reg <= s2_seen_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: permission check and lane access.
    // ------------------------------------------------------------------
    rpbm_region_check #(
        .ADDR_BITS (ADDR_BITS)
    ) u_check (
        .addr     (s1_addr_reg),
        .size     (s1_size_reg),
        .is_write (s1_write_reg),
        .regions  (regions),
        .kind     (s1_kind)
    );

    assign s1_ok       = (s1_kind == rpbm_pkg::FAULT_NONE);
    assign sticky_next = sticky_reg || !s1_ok;

    // Index of the last byte of the span.
    always_comb
    begin
        case (s1_size_reg)
            rpbm_pkg::SIZE_BYTE: s1_last = 2'd0;
            rpbm_pkg::SIZE_HALF: s1_last = 2'd1;
            default:             s1_last = 2'd3;
        endcase
    end

    // Lane b holds the bytes whose address is b modulo four. The span byte
    // that lands in lane b is at offset b minus the low address bits, and it
    // comes from write_data so that offset zero is the most significant.
    generate
        for (genvar b = 0; b < rpbm_pkg::BYTE_LANES; b++)
        begin : g_lane
            logic [1:0]           off;
            logic [1:0]           sel;
            logic [ADDR_BITS-1:0] byte_addr;
            logic                 active;

            assign off       = 2'(b) - s1_addr_reg[1:0];
            assign sel       = s1_last - off;
            assign byte_addr = s1_addr_reg + ADDR_BITS'(off);
            assign active    = (off <= s1_last);

            rpbm_bank #(
                .ROW_BITS (ROW_BITS)
            ) u_bank (
                .clk     (clk),
                .rd_en   (s1_fire && (s1_write_reg == rpbm_pkg::CMD_READ)),
                .wr_en   (s1_fire && (s1_write_reg == rpbm_pkg::CMD_WRITE)
                          && s1_ok && active),
                .row     (byte_addr[ADDR_BITS-1:2]),
                .wr_byte (s1_wdata_reg[{sel, 3'b000} +: 8]),
                .rd_byte (lane_rd[b])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 2: put the lane bytes back in span order, big-endian.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int j = 0; j < rpbm_pkg::BYTE_LANES; j++)
        begin
            span_byte[j] = lane_rd[2'(s2_lo_reg + 2'(j))];
        end
        case (s2_last_reg)
            2'd0:    rdata = {24'd0, span_byte[0]};
            2'd1:    rdata = {16'd0, span_byte[0], span_byte[1]};
            default: rdata = {span_byte[0], span_byte[1], span_byte[2], span_byte[3]};
        endcase
        if (s2_zero_reg)
        begin
            rdata = '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_seen_reg, out_kind_reg};

endmodule

>>> rtl/core/rpbm_checker.sv
// Port-level assertions for the region protected bus memory, bound to the top.
// Depends on rpbm_pkg and region_protected_bus_memory_macros.svh.
`timescale 1ns / 1ps
`include "region_protected_bus_memory_macros.svh"

module rpbm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [31:0]                     m_axis_tdata,
    input logic [2:0]                      m_axis_tuser
);

    logic faulted;

    assign faulted = (m_axis_tuser[1:0] != rpbm_pkg::FAULT_NONE);

    // A result held back by the sink does not change.
    `RPBM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // A faulting result always shows the sticky flag.
    `RPBM_ASSERT_SAME(a_fault_sets_seen, m_axis_tvalid && faulted, m_axis_tuser[2], "fault without fault_seen")

    // A faulting access reads as zero.
    `RPBM_ASSERT_SAME(a_fault_reads_zero, m_axis_tvalid && faulted, m_axis_tdata == 32'd0, "faulting access returned data")

    // Once shown, the sticky flag stays on every later result.
    `RPBM_ASSERT_NEXT(a_seen_sticky, m_axis_tvalid && m_axis_tuser[2], !m_axis_tvalid || m_axis_tuser[2], "fault_seen cleared")

endmodule

bind region_protected_bus_memory rpbm_checker u_rpbm_checker (.*);
